@@ rtl/core/gre_pkg.sv @@
package gre_pkg;

  localparam int GH_DEFAULT = 16;
  localparam int MG_DEFAULT = 256;

  localparam int Q_DEPTH = 2;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 280;
  localparam int CFG_DATA_W = 13;
  localparam int ADDR_W     = 24;
  localparam int PIX_W      = 32;
  localparam int GLYPH_W    = 8;

  localparam logic [12:0] LINE_WIDTH_RESET  = 13'd1024;
  localparam logic [8:0]  GLYPH_COUNT_RESET = 9'd256;

  // register indexes on the configuration port
  localparam logic CFG_LINE_WIDTH  = 1'b0;
  localparam logic CFG_GLYPH_COUNT = 1'b1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DRAW = 1'b1
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_t;

  // classified command as held in the queue
  typedef struct packed {
    op_t         kind;
    logic        wr_ok;
    logic [7:0]  glyph;
    logic [3:0]  row;
    logic [7:0]  bits;
    logic [8:0]  cell_x;
    logic [7:0]  cell_y;
    logic [31:0] fg_color;
    logic [31:0] bg_color;
  } cmd_t;

endpackage

@@ rtl/core/gre_front.sv @@
module gre_front
  import gre_pkg::*;
#(
  parameter int GLYPH_HEIGHT = GH_DEFAULT,
  parameter int MAX_GLYPHS   = MG_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  output logic                  q_push,
  output cmd_t                  q_cmd,
  input  logic                  q_full,
  output logic [12:0]           line_width
);

  logic [12:0] line_width_r;
  logic [8:0]  glyph_count_r;

  logic [7:0]  char_code;
  logic        use_zero;
  logic        glyph_ok;
  logic        row_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r  <= LINE_WIDTH_RESET;
      glyph_count_r <= GLYPH_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINE_WIDTH:  line_width_r  <= cfg_wdata[12:0];
        CFG_GLYPH_COUNT: glyph_count_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  assign line_width = line_width_r;
  assign in_tready  = !q_full;
  assign q_push     = in_tvalid && !q_full;

  assign char_code = in_tdata[7:0];

  // negative codes (as signed bytes), code zero and codes past the font draw glyph zero
  assign use_zero = (char_code == 8'd0) || char_code[7]
                 || ({1'b0, char_code} >= glyph_count_r)
                 || ({1'b0, char_code} >= 9'(MAX_GLYPHS));

  assign glyph_ok = {1'b0, in_tdata[96:89]} < 9'(MAX_GLYPHS);
  assign row_ok   = {2'b00, in_tdata[100:97]} < 6'(GLYPH_HEIGHT);

  always_comb begin
    q_cmd          = '0;
    q_cmd.kind     = op_t'(in_tuser);
    q_cmd.cell_x   = in_tdata[16:8];
    q_cmd.cell_y   = in_tdata[24:17];
    q_cmd.fg_color = in_tdata[56:25];
    q_cmd.bg_color = in_tdata[88:57];
    q_cmd.bits     = in_tdata[108:101];
    q_cmd.row      = in_tdata[100:97];
    unique case (op_t'(in_tuser))
      OP_LOAD: begin
        q_cmd.glyph = in_tdata[96:89];
        q_cmd.wr_ok = glyph_ok && row_ok;
      end
      OP_DRAW: begin
        q_cmd.glyph = use_zero ? 8'd0 : char_code;
        q_cmd.wr_ok = 1'b0;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/gre_queue.sv @@
module gre_queue
  import gre_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cmd_t             slot_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = count_r == CNT_W'(Q_DEPTH);
  assign valid = count_r != '0;
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/core/gre_back.sv @@
module gre_back
  import gre_pkg::*;
#(
  parameter int GLYPH_HEIGHT = GH_DEFAULT,
  parameter int MAX_GLYPHS   = MG_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [12:0]           line_width,
  input  logic                  q_valid,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  localparam int DEPTH = MAX_GLYPHS * GLYPH_HEIGHT;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int ROW_W = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;

  logic [GLYPH_W-1:0] store [DEPTH];

  bk_state_t          state_r, state_nxt;
  logic [ROW_W-1:0]   row_r;
  logic [IDX_W-1:0]   base_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [PIX_W-1:0]   fg_r, bg_r;

  logic               rd_valid_r, rd_valid_nxt;
  logic [GLYPH_W-1:0] rd_bits_r;
  logic [ADDR_W-1:0]  rd_addr_r;
  logic               rd_last_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  logic               out_free;
  logic               b_move;
  logic               issue;
  logic               last_issue;
  logic               pop_draw;
  logic               store_we;
  logic [IDX_W-1:0]   wr_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic [12:0]        line0;
  logic [25:0]        prod;
  logic [ADDR_W-1:0]  addr0;
  logic [OUT_DATA_W-1:0] pix_word;

  assign out_free   = !out_valid_r || out_tready;
  assign b_move     = rd_valid_r && out_free;
  assign last_issue = issue && (row_r == ROW_W'(GLYPH_HEIGHT - 1));
  assign pop_draw   = q_pop && (q_cmd.kind == OP_DRAW);
  assign store_we   = q_pop && (q_cmd.kind == OP_LOAD) && q_cmd.wr_ok;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (pop_draw) state_nxt = BK_RUN;
      BK_RUN:  if (last_issue) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    issue = 1'b0;
    unique case (state_r)
      // take the next command once the read stage drains or hands on this cycle
      BK_IDLE: q_pop = q_valid && (!rd_valid_r || b_move);
      BK_RUN:  issue = !rd_valid_r || b_move;
      default: ;
    endcase
  end

  assign wr_idx = IDX_W'(q_cmd.glyph * GLYPH_HEIGHT + q_cmd.row);
  assign rd_idx = base_r + IDX_W'(row_r);

  // leftmost pixel of the top row; later rows step by the line stride
  assign line0 = 13'(q_cmd.cell_y * GLYPH_HEIGHT);
  assign prod  = line_width * line0;
  assign addr0 = prod[ADDR_W-1:0] + {12'b0, q_cmd.cell_x, 3'b000};

  always_comb begin
    pix_word = '0;
    pix_word[ADDR_W-1:0] = rd_addr_r;
    for (int p = 0; p < GLYPH_W; p++) begin
      pix_word[ADDR_W + PIX_W*p +: PIX_W] = rd_bits_r[GLYPH_W-1-p] ? fg_r : bg_r;
    end
  end

  assign rd_valid_nxt  = issue ? 1'b1 : (b_move ? 1'b0 : rd_valid_r);
  assign out_valid_nxt = b_move ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_draw) begin
      row_r  <= '0;
      base_r <= IDX_W'(q_cmd.glyph * GLYPH_HEIGHT);
      addr_r <= addr0;
      fg_r   <= q_cmd.fg_color;
      bg_r   <= q_cmd.bg_color;
    end else if (issue) begin
      row_r  <= row_r + 1'b1;
      addr_r <= addr_r + {11'b0, line_width};
    end
    if (issue) begin
      rd_addr_r <= addr_r;
      rd_last_r <= last_issue;
    end
    if (b_move) begin
      out_data_r <= pix_word;
      out_last_r <= rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[wr_idx] <= q_cmd.bits;
    end
    if (issue) begin
      rd_bits_r <= store[rd_idx];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/core/glyph_row_expander.sv @@
// Load transaction: no result; with the back end idle the command leaves the queue and its
// glyph row is written to the store. Draw transaction: once taken, each row is read from the
// store once and passes the output register, one row a cycle while the output takes them.
// A two-entry command queue lets input be taken while the row sequencer is busy.
// Reset (rst_n low, synchronous) empties the queue and pipeline and restores the
// configuration registers; the glyph store is not cleared and holds nothing until loaded.
module glyph_row_expander
  import gre_pkg::*;
#(
  parameter int GLYPH_HEIGHT = GH_DEFAULT,
  parameter int MAX_GLYPHS   = MG_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // char_code[7:0], cell_x[16:8], cell_y[24:17], fg_color[56:25], bg_color[88:57],
  // load_glyph[96:89], load_row[100:97], load_bits[108:101], zero pad[111:109]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // row_address[23:0], pixel_0[55:24], pixel_1[87:56], pixel_2[119:88],
  // pixel_3[151:120], pixel_4[183:152], pixel_5[215:184], pixel_6[247:216],
  // pixel_7[279:248]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  logic        q_push;
  cmd_t        push_cmd;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  cmd_t        q_head;
  logic [12:0] line_width;

  gre_front #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .MAX_GLYPHS   (MAX_GLYPHS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_push     (q_push),
    .q_cmd      (push_cmd),
    .q_full     (q_full),
    .line_width (line_width)
  );

  gre_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  gre_back #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .MAX_GLYPHS   (MAX_GLYPHS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .line_width (line_width),
    .q_valid    (q_valid),
    .q_cmd      (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ rtl/core/gre_checker.sv @@
module gre_checker
  import gre_pkg::*;
#(
  parameter int GLYPH_HEIGHT = GH_DEFAULT
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_we,
  input logic                  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  logic [12:0]       lw_r;
  logic              open_r;
  logic [ADDR_W-1:0] prev_addr_r;
  logic              out_acc;

  assign out_acc = out_tvalid && out_tready;

  // shadow the stride and the last row transaction of the character in progress
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r   <= LINE_WIDTH_RESET;
      open_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == CFG_LINE_WIDTH)) begin
        lw_r <= cfg_wdata[12:0];
      end
      if (out_acc) begin
        open_r <= !out_tlast;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_addr_r <= out_tdata[ADDR_W-1:0];
    end
  end

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("output valid or input stalled after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output transaction changed");

  a_row_stride: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && open_r |-> out_tdata[ADDR_W-1:0] == 24'(prev_addr_r + {11'b0, lw_r}))
    else $error("row address does not advance by the line stride");

  a_single_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (GLYPH_HEIGHT == 1) |-> out_tlast)
    else $error("single-row glyph without last flag");

endmodule

bind glyph_row_expander gre_checker #(.GLYPH_HEIGHT(GLYPH_HEIGHT)) u_gre_checker (.*);
